>>> hw/rtl/hsort_pkg.sv
// ----------------------------------------------------------------------------
// hsort_pkg
// Shared item types and constants for the heap sorter.
// ----------------------------------------------------------------------------
package hsort_pkg;

  localparam int unsigned DATA_W = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     final_res;
    logic                     overflow;
  } out_item_t;

endpackage

>>> hw/rtl/hsort_ram.sv
// ----------------------------------------------------------------------------
// hsort_ram
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hsort_ram #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [ADDR_W-1:0]                     waddr_i,
  input  logic signed [hsort_pkg::DATA_W-1:0]   wdata_i,
  input  logic [ADDR_W-1:0]                     raddr_i,
  output logic signed [hsort_pkg::DATA_W-1:0]   rdata_o
);

  logic signed [hsort_pkg::DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hw/rtl/heap_sorter.sv
// ----------------------------------------------------------------------------
// heap_sorter
// Collects a set of signed values, heapsorts them in place in a store with one
// read port and one write port and one shared comparator, then streams them out in ascending order.
// ----------------------------------------------------------------------------
// Loading: one item per cycle while in_ready_o is high.
// Sorting: bounded by the single read port of the element store (one access
//   per cycle).
// Output: each result is held until out_ready_i takes it; the next one is then read from the store.
// Reset clears the element count, the dropped flag and the sequencer; the store
//   contents are left undefined and need no clearing pass.
module heap_sorter #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  hsort_pkg::in_item_t   in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hsort_pkg::out_item_t  out_item_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CH_W  = IDX_W + 1;

  typedef enum logic [3:0] {
    S_LOAD,
    S_RD_TOP,
    S_GET_TOP,
    S_CHK,
    S_RD_R,
    S_PICK,
    S_CMP,
    S_NEXT,
    S_SWAP0,
    S_SWAP_I,
    S_SWAP_WR,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_WAIT
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             drop_q, drop_d;
  logic [CNT_W-1:0] size_q, size_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic [IDX_W-1:0] cidx_q, cidx_d;
  logic [IDX_W-1:0] i_q, i_d;
  logic [IDX_W-1:0] j_q, j_d;
  logic             build_q, build_d;

  logic signed [hsort_pkg::DATA_W-1:0] held_q, held_d;
  logic signed [hsort_pkg::DATA_W-1:0] cval_q, cval_d;

  hsort_pkg::out_item_t out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  // store port
  logic                                we;
  logic [IDX_W-1:0]                    waddr;
  logic signed [hsort_pkg::DATA_W-1:0] wdata;
  logic [IDX_W-1:0]                    raddr;
  logic signed [hsort_pkg::DATA_W-1:0] rdata;

  // shared compare unit: cval_q < cmp_b
  logic signed [hsort_pkg::DATA_W-1:0] cmp_b;
  logic                                cmp_lt;

  logic [CH_W-1:0]  left;
  logic [CH_W-1:0]  right;
  logic [CNT_W-1:0] new_cnt;
  logic             in_fire;

  hsort_ram #(
    .DEPTH  (CAPACITY),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign cmp_b  = (state_q == S_PICK) ? rdata : held_q;
  assign cmp_lt = cval_q < cmp_b;

  assign left    = {pos_q, 1'b1};
  assign right   = left + CH_W'(1);
  assign in_fire = in_valid_i && in_ready_o;
  assign new_cnt = (cnt_q < CNT_W'(CAPACITY)) ? cnt_q + CNT_W'(1) : cnt_q;

  assign in_ready_o  = (state_q == S_LOAD);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    drop_d      = drop_q;
    size_d      = size_q;
    k_d         = k_q;
    pos_d       = pos_q;
    cidx_d      = cidx_q;
    i_d         = i_q;
    j_d         = j_q;
    build_d     = build_q;
    held_d      = held_q;
    cval_d      = cval_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    we          = 1'b0;
    waddr       = pos_q;
    wdata       = held_q;
    raddr       = '0;

    case (state_q)
      S_LOAD: begin
        if (in_fire) begin
          if (cnt_q < CNT_W'(CAPACITY)) begin
            we    = 1'b1;
            waddr = IDX_W'(cnt_q);
            wdata = in_item_i.value;
          end else begin
            drop_d = 1'b1;
          end
          cnt_d = new_cnt;
          if (in_item_i.last) begin
            size_d = new_cnt;
            if ((new_cnt >> 1) != '0) begin
              k_d     = new_cnt >> 1;
              pos_d   = IDX_W'((new_cnt >> 1) - CNT_W'(1));
              build_d = 1'b1;
              state_d = S_RD_TOP;
            end else begin
              j_d     = '0;
              state_d = S_OUT_RD;
            end
          end
        end
      end
      S_RD_TOP: begin
        raddr   = pos_q;
        state_d = S_GET_TOP;
      end
      S_GET_TOP: begin
        held_d  = rdata;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (left < CH_W'(size_q)) begin
          raddr   = IDX_W'(left);
          state_d = S_RD_R;
        end else begin
          // hole reached a leaf: drop the held value in
          we      = 1'b1;
          state_d = S_NEXT;
        end
      end
      S_RD_R: begin
        cval_d = rdata;
        cidx_d = IDX_W'(left);
        if (right < CH_W'(size_q)) begin
          raddr   = IDX_W'(right);
          state_d = S_PICK;
        end else begin
          state_d = S_CMP;
        end
      end
      S_PICK: begin
        if (cmp_lt) begin
          cval_d = rdata;
          cidx_d = IDX_W'(right);
        end
        state_d = S_CMP;
      end
      S_CMP: begin
        we = 1'b1;
        if (cmp_lt) begin
          state_d = S_NEXT;
        end else begin
          // larger child moves up into the hole
          wdata   = cval_q;
          pos_d   = cidx_q;
          state_d = S_CHK;
        end
      end
      S_NEXT: begin
        if (build_q) begin
          if (k_q > CNT_W'(1)) begin
            k_d     = k_q - CNT_W'(1);
            pos_d   = IDX_W'(k_q - CNT_W'(2));
            state_d = S_RD_TOP;
          end else begin
            build_d = 1'b0;
            i_d     = IDX_W'(cnt_q - CNT_W'(1));
            state_d = S_SWAP0;
          end
        end else if (i_q > IDX_W'(1)) begin
          i_d     = i_q - IDX_W'(1);
          state_d = S_SWAP0;
        end else begin
          j_d     = '0;
          state_d = S_OUT_RD;
        end
      end
      S_SWAP0: begin
        raddr   = '0;
        state_d = S_SWAP_I;
      end
      S_SWAP_I: begin
        raddr   = i_q;
        cval_d  = rdata;
        state_d = S_SWAP_WR;
      end
      S_SWAP_WR: begin
        // root goes to the end, old end value sifts down from the root
        we      = 1'b1;
        waddr   = i_q;
        wdata   = cval_q;
        held_d  = rdata;
        pos_d   = '0;
        size_d  = CNT_W'(i_q);
        state_d = S_CHK;
      end
      S_OUT_RD: begin
        raddr   = j_q;
        state_d = S_OUT_LD;
      end
      S_OUT_LD: begin
        out_d.sorted_value = rdata;
        out_d.final_res    = (j_q == IDX_W'(cnt_q - CNT_W'(1)));
        out_d.overflow     = drop_q;
        out_valid_d        = 1'b1;
        state_d            = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (out_q.final_res) begin
            cnt_d   = '0;
            drop_d  = 1'b0;
            state_d = S_LOAD;
          end else begin
            j_d     = j_q + IDX_W'(1);
            raddr   = j_q + IDX_W'(1);
            state_d = S_OUT_LD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      cnt_q       <= '0;
      drop_q      <= 1'b0;
      build_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      drop_q      <= drop_d;
      build_q     <= build_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q <= size_d;
    k_q    <= k_d;
    pos_q  <= pos_d;
    cidx_q <= cidx_d;
    i_q    <= i_d;
    j_q    <= j_d;
    held_q <= held_d;
    cval_q <= cval_d;
    out_q  <= out_d;
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("result pending while accepting input");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("element count beyond capacity");

  a_final_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_item_o.final_res) |=> (in_ready_o && cnt_q == '0))
    else $error("run end did not return to loading");

  a_child_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (CNT_W'(cidx_q) < size_q && CNT_W'(pos_q) < size_q))
    else $error("sift index outside heap");

endmodule
